// ===== hw/rtl/ucfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ucfr_pkg
// Shared types and constants of the adapter serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ucfr_pkg;

    localparam logic [7:0] C_SYNC_BYTE   = 8'haa;
    localparam logic [7:0] C_CMD_TYPE    = 8'h55;
    localparam logic [3:0] C_DATA_NIBBLE = 4'hc;
    localparam logic [4:0] C_DATA_EXTRA  = 5'd4;
    localparam logic [4:0] C_CMD_LAST    = 5'd19;
    localparam logic [4:0] C_CMD_SUM_END = 5'd18;
    localparam logic [6:0] C_MAX_LEN     = 7'd32;
    localparam logic [5:0] C_LEN_RESET   = 6'd32;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_SKIP    = 3'd1;
    localparam logic [2:0] KIND_CMD     = 3'd2;
    localparam logic [2:0] KIND_DATA    = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CSUM = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] position;
        logic [2:0] frame_kind;
        logic       last;
        logic       overflow;
        logic       check;
        logic [7:0] sum;
    } t_entry;

    function automatic logic [2:0] f_kind_of_type(input logic [7:0] t);
        logic [2:0] k;
        if (t == C_CMD_TYPE) begin
            k = KIND_CMD;
        end else if (t[7:4] == C_DATA_NIBBLE) begin
            k = KIND_DATA;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucfr_front.sv =====
// ----------------------------------------------------------------------------
// ucfr_front
// Accepts received bytes, tracks frame position, type and running sum, and
// classifies each byte into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfr_front
    import ucfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr,
    input  wire logic [5:0] i_cfg_len,
    input  wire logic       i_take,
    input  wire logic [7:0] i_rx_byte,
    output t_entry          o_entry
);

    logic [5:0] r_max_len;
    logic [4:0] r_byte_count, n_byte_count;
    logic [7:0] r_type_byte, n_type_byte;
    logic [7:0] r_running_sum, n_running_sum;
    logic [6:0] limit;
    logic [2:0] kind;
    logic       last;

    assign limit = ({1'b0, r_max_len} < C_MAX_LEN) ? {1'b0, r_max_len} : C_MAX_LEN;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_type_byte   = r_type_byte;
        n_running_sum = r_running_sum;
        kind          = KIND_NONE;
        last          = 1'b0;
        o_entry       = '0;
        o_entry.data_byte = i_rx_byte;
        o_entry.position  = r_byte_count;
        o_entry.sum       = r_running_sum;
        if ({2'b00, r_byte_count} == limit) begin
            kind = (r_byte_count >= 5'd2) ? f_kind_of_type(r_type_byte) : KIND_NONE;
            last = 1'b1;
            o_entry.overflow = 1'b1;
        end else if (r_byte_count == 5'd0) begin
            if (i_rx_byte != C_SYNC_BYTE) begin
                kind = KIND_SKIP;
                last = 1'b1;
            end else begin
                n_byte_count  = 5'd1;
                n_running_sum = '0;
            end
        end else if (r_byte_count == 5'd1) begin
            n_type_byte = i_rx_byte;
            kind        = f_kind_of_type(i_rx_byte);
            if (kind == KIND_UNKNOWN) begin
                last = 1'b1;
            end else begin
                n_byte_count = 5'd2;
            end
        end else begin
            kind = f_kind_of_type(r_type_byte);
            if (kind == KIND_CMD) begin
                if (r_byte_count >= C_CMD_LAST) begin
                    last          = 1'b1;
                    o_entry.check = 1'b1;
                end else if (r_byte_count <= C_CMD_SUM_END) begin
                    n_running_sum = r_running_sum + i_rx_byte;
                end
            end else if (kind == KIND_DATA) begin
                if (r_byte_count >= {1'b0, r_type_byte[3:0]} + C_DATA_EXTRA) begin
                    last = 1'b1;
                end
            end else begin
                last = 1'b1;
            end
            if (!last) begin
                n_byte_count = r_byte_count + 5'd1;
            end
        end
        if (last) begin
            n_byte_count  = '0;
            n_type_byte   = '0;
            n_running_sum = '0;
        end
        o_entry.frame_kind = kind;
        o_entry.last       = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= C_LEN_RESET;
            r_byte_count  <= '0;
            r_type_byte   <= '0;
            r_running_sum <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_max_len <= i_cfg_len;
            end
            if (i_take) begin
                r_byte_count  <= n_byte_count;
                r_type_byte   <= n_type_byte;
                r_running_sum <= n_running_sum;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ucfr_queue.sv =====
// ----------------------------------------------------------------------------
// ucfr_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfr_queue
    import ucfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output logic        o_full,
    output logic        o_empty,
    output logic [1:0]  o_count
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ucfr_back.sv =====
// ----------------------------------------------------------------------------
// ucfr_back
// Resolves checksum and overflow status and holds the result in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ucfr_back
    import ucfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_avail,
    input  wire t_entry     i_entry,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic [4:0]      o_position,
    output logic [2:0]      o_frame_kind,
    output logic            o_last,
    output logic [1:0]      o_status
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic [4:0] r_position;
    logic [2:0] r_frame_kind;
    logic       r_last;
    logic [1:0] r_status;
    logic [1:0] n_status;

    assign o_pop = i_avail && (!r_valid || i_out_ready);

    always_comb begin
        if (i_entry.overflow) begin
            n_status = STATUS_OVF;
        end else if (i_entry.check && (i_entry.sum != i_entry.data_byte)) begin
            n_status = STATUS_CSUM;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data_byte  <= i_entry.data_byte;
            r_position   <= i_entry.position;
            r_frame_kind <= i_entry.frame_kind;
            r_last       <= i_entry.last;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_data_byte  = r_data_byte;
    assign o_position   = r_position;
    assign o_frame_kind = r_frame_kind;
    assign o_last       = r_last;
    assign o_status     = r_status;

endmodule

`default_nettype wire

// ===== hw/rtl/usb_can_adapter_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// usb_can_adapter_frame_receiver
// Deframes adapter serial bytes: echoes each byte with position, frame kind,
// last flag and checksum or overflow status.
// ----------------------------------------------------------------------------
// result path: each byte is registered in the queue, then in the output register
// 1 byte per cycle unless the queue is full; front state and 8-bit sum combinational
// a two-entry queue lets the front keep taking bytes while a result is stalled
// reset: synchronous active low, clears frame state, length limit back to 32
`default_nettype none

module usb_can_adapter_frame_receiver
    import ucfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [5:0] i_max_frame_len,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic [4:0]      o_position,
    output logic [2:0]      o_frame_kind,
    output logic            o_last,
    output logic [1:0]      o_status
);

    t_entry     front_entry;
    t_entry     queue_entry;
    logic       take;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic [1:0] q_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign take        = i_in_valid && o_in_ready;

    ucfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (i_cfg_valid && o_cfg_ready),
        .i_cfg_len (i_max_frame_len),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_entry   (front_entry)
    );

    ucfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ucfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (!q_empty),
        .i_entry      (queue_entry),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_byte  (o_data_byte),
        .o_position   (o_position),
        .o_frame_kind (o_frame_kind),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("queue count out of range");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_OVF) |-> o_last)
        else $error("overflow result without last");

    a_csum_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STATUS_CSUM) |->
            o_last && (o_frame_kind == KIND_CMD) && (o_position == C_CMD_LAST))
        else $error("checksum status outside command frame end");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out_valid)
        else $error("popped entry not presented");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adapter serial frame receiver. Byte streams of
// unsynced noise, unknown types, data frames and command frames (good and bad
// checksums) are sent under several length limits. Every echoed byte is
// compared with a local model of the deframer, with random idling on both
// sides, a long output hold-off and pauses of the sender.
// ----------------------------------------------------------------------------

module tb_top;

    import ucfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 200;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] position;
        logic [2:0] frame_kind;
        logic       last;
        logic [1:0] status;
    } t_echo;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_max_frame_len;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_data_byte;
    logic [4:0] o_position;
    logic [2:0] o_frame_kind;
    logic       o_last;
    logic [1:0] o_status;

    // model of the deframer
    logic [5:0] frame_limit;
    logic [5:0] frame_count;
    logic [7:0] frame_type;
    logic [7:0] frame_sum;

    t_echo       echo_q[$];
    int unsigned err_cnt;
    int unsigned sent_cnt;
    int unsigned cycle_cnt;
    bit          idle_on;
    bit          hold_req;

    usb_can_adapter_frame_receiver u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_max_frame_len (i_max_frame_len),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_position      (o_position),
        .o_frame_kind    (o_frame_kind),
        .o_last          (o_last),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL usb_can_adapter_frame_receiver");
        $finish;
    end

    function automatic logic [2:0] kind_from_type(input logic [7:0] t);
        if (t == C_CMD_TYPE) begin
            return KIND_CMD;
        end else if (t[7:4] == C_DATA_NIBBLE) begin
            return KIND_DATA;
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic void restart_frame();
        frame_count = '0;
        frame_type  = '0;
        frame_sum   = '0;
    endfunction

    function automatic t_echo predict_echo(input logic [7:0] b);
        t_echo      e;
        logic [6:0] lim;
        logic [5:0] pos;
        lim = ({1'b0, frame_limit} < C_MAX_LEN) ? {1'b0, frame_limit} : C_MAX_LEN;
        pos = frame_count;
        e.data_byte  = b;
        e.position   = pos[4:0];
        e.frame_kind = KIND_NONE;
        e.last       = 1'b0;
        e.status     = STATUS_OK;
        if ({1'b0, pos} == lim) begin
            e.frame_kind = (pos >= 6'd2) ? kind_from_type(frame_type) : KIND_NONE;
            e.last       = 1'b1;
            e.status     = STATUS_OVF;
            restart_frame();
        end else if (pos == 6'd0) begin
            if (b != C_SYNC_BYTE) begin
                e.frame_kind = KIND_SKIP;
                e.last       = 1'b1;
                restart_frame();
            end else begin
                frame_count = 6'd1;
                frame_sum   = '0;
            end
        end else if (pos == 6'd1) begin
            frame_type   = b;
            e.frame_kind = kind_from_type(b);
            if (e.frame_kind == KIND_UNKNOWN) begin
                e.last = 1'b1;
                restart_frame();
            end else begin
                frame_count = 6'd2;
            end
        end else begin
            e.frame_kind = kind_from_type(frame_type);
            if (e.frame_kind == KIND_CMD) begin
                if (pos >= 6'(C_CMD_LAST)) begin
                    e.last = 1'b1;
                    if (frame_sum != b) begin
                        e.status = STATUS_CSUM;
                    end
                end else if (pos <= 6'(C_CMD_SUM_END)) begin
                    frame_sum = frame_sum + b;
                end
            end else if (e.frame_kind == KIND_DATA) begin
                if (pos >= 6'(frame_type[3:0]) + 6'(C_DATA_EXTRA)) begin
                    e.last = 1'b1;
                end
            end else begin
                e.last = 1'b1;
            end
            if (e.last) begin
                restart_frame();
            end else begin
                frame_count = pos + 6'd1;
            end
        end
        return e;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_echo e;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (echo_q.size() == 0) begin
                $error("unexpected result transfer, data_byte %0d", o_data_byte);
                err_cnt++;
            end else begin
                e = echo_q.pop_front();
                check_field("data_byte", e.data_byte, o_data_byte);
                check_field("position", 8'(e.position), 8'(o_position));
                check_field("frame_kind", 8'(e.frame_kind), 8'(o_frame_kind));
                check_field("last", 8'(e.last), 8'(o_last));
                check_field("status", 8'(e.status), 8'(o_status));
            end
        end
    end

    // receiver side: random stalls and the long hold-off
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        echo_q.push_back(predict_echo(b));
        sent_cnt++;
    endtask

    task automatic wait_for_echoes();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (echo_q.size() != 0);
    endtask

    task automatic write_frame_limit(input logic [5:0] len);
        wait_for_echoes();
        i_cfg_valid     <= 1'b1;
        i_max_frame_len <= len;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        frame_limit = len;
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  t;
        logic [7:0]  sum;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_byte(C_SYNC_BYTE);
            send_byte(C_CMD_TYPE);
            sum = '0;
            for (int i = 2; i <= 18; i++) begin
                b = 8'($urandom);
                sum = sum + b;
                send_byte(b);
            end
            if ($urandom_range(0, 2) == 0) begin
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            end
            send_byte(sum);
        end else if (pick < 75) begin
            t = {C_DATA_NIBBLE, 4'($urandom)};
            send_byte(C_SYNC_BYTE);
            send_byte(t);
            n = int'(t[3:0]) + 3;
            repeat (n) send_byte(8'($urandom));
        end else if (pick < 85) begin
            do t = 8'($urandom); while (kind_from_type(t) != KIND_UNKNOWN);
            send_byte(C_SYNC_BYTE);
            send_byte(t);
        end else begin
            // noise, sometimes a lone sync byte that the next frame breaks
            send_byte(($urandom_range(0, 3) == 0) ? C_SYNC_BYTE : 8'($urandom));
        end
    endtask

    task automatic send_random_run(input int unsigned budget);
        int unsigned start;
        start = sent_cnt;
        while (sent_cnt - start < budget) begin
            send_random_frame();
        end
    endtask

    task automatic test_frame_kinds();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(C_SYNC_BYTE);
        send_byte(8'h00);
        send_byte(C_SYNC_BYTE);
        send_byte({C_DATA_NIBBLE, 4'h0});
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
    endtask

    task automatic test_limit_extremes();
        write_frame_limit(6'd0);
        send_byte(C_SYNC_BYTE);
        write_frame_limit(6'd1);
        send_byte(C_SYNC_BYTE);
        send_byte(C_CMD_TYPE);
        write_frame_limit(6'd3);
        send_byte(C_SYNC_BYTE);
        send_byte(C_CMD_TYPE);
        send_byte(8'h12);
        send_byte(8'h34);
        write_frame_limit(6'd63);
        send_byte(C_SYNC_BYTE);
        send_byte(8'hff);
    endtask

    task automatic test_random_frames();
        logic [5:0] limits [8];
        limits = '{6'd32, 6'd63, 6'd20, 6'd19, 6'd2, 6'd1, 6'd0, 6'd0};
        limits[7] = 6'($urandom_range(3, 31));
        idle_on = 1'b1;
        foreach (limits[i]) begin
            write_frame_limit(limits[i]);
            send_random_run((limits[i] == 6'd0) ? 20 : 90);
        end
    endtask

    task automatic test_output_hold();
        write_frame_limit(C_LEN_RESET);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_random_run(40);
        wait_for_echoes();
    endtask

    task automatic test_sender_pause();
        idle_on = 1'b1;
        repeat (3) begin
            send_random_run(15);
            wait_for_echoes();
        end
    endtask

    task automatic test_back_to_back();
        write_frame_limit(6'd32);
        idle_on = 1'b0;
        send_random_run(80);
    endtask

    initial begin
        err_cnt   = 0;
        sent_cnt  = 0;
        idle_on   = 1'b0;
        hold_req  = 1'b0;
        frame_limit = C_LEN_RESET;
        restart_frame();
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_max_frame_len <= '0;
        i_in_valid      <= 1'b0;
        i_rx_byte       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_kinds();
        test_limit_extremes();
        test_random_frames();
        test_output_hold();
        test_sender_pause();
        test_back_to_back();

        wait_for_echoes();
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS usb_can_adapter_frame_receiver");
        end else begin
            $display("FAIL usb_can_adapter_frame_receiver");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ucfr_pkg.sv
hw/rtl/ucfr_front.sv
hw/rtl/ucfr_queue.sv
hw/rtl/ucfr_back.sv
hw/rtl/usb_can_adapter_frame_receiver.sv
tb/sv/tb_top.sv
